// ===== rtl/rbq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbq_pkg
// Shared types, field widths, operation and status codes, and the tag
// reduction helper for the reorder buffer queue.
// ----------------------------------------------------------------------------
package rbq_pkg;

   // field widths, fixed by the request and response formats
   localparam int MODE_W   = 3;
   localparam int TAG_W    = 6;
   localparam int PC_W     = 32;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 3;
   localparam int OCC_W    = 6;

   // default queue depth and physical register count
   localparam int DEPTH_DEF = 32;
   localparam int unsigned PHYS_REGS = 64;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_ALLOC  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_RETIRE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_MARK   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_READ   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FIND   = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NOPC  = 3'd4;

   // request payload
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [TAG_W-1:0]  new_tag;
      logic [TAG_W-1:0]  old_tag;
      logic [PC_W-1:0]   instr_pc;
      logic [POS_W-1:0]  position;
   } req_type;

   // response payload
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TAG_W-1:0]    entry_tag;
      logic [TAG_W-1:0]    entry_old_tag;
      logic [PC_W-1:0]     entry_pc;
      logic                entry_dispatched;
      logic [POS_W-1:0]    found_position;
      logic [OCC_W-1:0]    occupancy;
   } rsp_type;

   // one stored entry, dispatched flag kept in its own memory
   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [TAG_W-1:0] old_tag;
      logic [PC_W-1:0]  pc;
   } entry_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_READ   = 3'b010,
      ST_SEARCH = 3'b100
   } state_type;

   // tag modulo physical register count, a constant lookup over all tag values
   function automatic logic [TAG_W-1:0] tag_mod(input logic [TAG_W-1:0] value);
      logic [TAG_W-1:0] result;
      result = '0;
      for (int i = 0; i < 2 ** TAG_W; i++) begin
         if (value == TAG_W'(i)) begin
            result = TAG_W'(i % PHYS_REGS);
         end
      end
      return result;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/reorder_buffer_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// reorder_buffer_queue
// In-order reorder buffer kept as a circular queue in two memories: one for
// the tags and pc, one for the dispatched flags. Each request carries one
// operation: allocate, retire, mark dispatched, read or find by pc.
//
//   channel   direction   handshake              payload
//   req_      in          req_valid/req_ready    rbq_pkg::req_type
//   rsp_      out         rsp_valid/rsp_ready    rbq_pkg::rsp_type
//
// Allocate, mark, rejected and unused operations answer in the cycle after the
// request; retire and read pass through the memory read register first.
// Find by pc reads one entry per cycle from the oldest on, until the match or
// the last occupied entry.
// Reset clears state, head, count, search index and response valid only; entry storage is not cleared.
// A new request is taken once the controller is idle and the response
// register is empty or being emptied in the same cycle.
// ----------------------------------------------------------------------------
module reorder_buffer_queue #(
   parameter int DEPTH = rbq_pkg::DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire rbq_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rbq_pkg::rsp_type      rsp_data
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > rbq_pkg::POS_W) ? CNT_W : rbq_pkg::POS_W;
   localparam int ENT_W = $bits(rbq_pkg::entry_type);

   rbq_pkg::state_type  state_ff, state_in;
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [rbq_pkg::PC_W-1:0] pc_ff, pc_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rbq_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   logic                req_fire;
   logic                full;
   logic                empty;
   logic                pos_ok;
   logic [IDX_W-1:0]    head_next;
   logic [CNT_W-1:0]    idx_next;
   logic [CNT_W-1:0]    addr_offset;
   logic [IDX_W-1:0]    slot;

   logic                ent_we;
   rbq_pkg::entry_type  ent_wdata;
   logic [ENT_W-1:0]    ent_rdata;
   rbq_pkg::entry_type  ent_rd;
   logic                flag_we;
   logic                flag_wdata;
   logic                flag_rdata;

   // handshake and queue status
   assign req_ready = (state_ff == rbq_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign pos_ok    = CMP_W'(req_data.position) < CMP_W'(count_ff);
   assign head_next = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign idx_next  = idx_ff + 1'b1;

   // offset from head for the single address calculation
   always_comb begin
      if (state_ff == rbq_pkg::ST_SEARCH) begin
         addr_offset = idx_next;
      end else begin
         case (req_data.mode)
            rbq_pkg::MODE_ALLOC: addr_offset = count_ff;
            rbq_pkg::MODE_MARK,
            rbq_pkg::MODE_READ:  addr_offset = CNT_W'(req_data.position);
            default:             addr_offset = '0;
         endcase
      end
   end

   rbq_addr #(
      .DEPTH (DEPTH)
   ) u_addr (
      .head   (head_ff),
      .offset (addr_offset),
      .slot   (slot)
   );

   // memory write controls
   assign ent_we = req_fire && (req_data.mode == rbq_pkg::MODE_ALLOC) && !full;
   assign ent_wdata.tag     = rbq_pkg::tag_mod(req_data.new_tag);
   assign ent_wdata.old_tag = rbq_pkg::tag_mod(req_data.old_tag);
   assign ent_wdata.pc      = req_data.instr_pc;

   assign flag_we = req_fire && (((req_data.mode == rbq_pkg::MODE_ALLOC) && !full) ||
                                 ((req_data.mode == rbq_pkg::MODE_MARK) && pos_ok));
   assign flag_wdata = (req_data.mode == rbq_pkg::MODE_MARK);

   rbq_ram #(
      .WIDTH (ENT_W),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (slot),
      .wr_data (ent_wdata),
      .rd_addr (slot),
      .rd_data (ent_rdata)
   );

   rbq_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_flag_ram (
      .clock   (clock),
      .wr_en   (flag_we),
      .wr_addr (slot),
      .wr_data (flag_wdata),
      .rd_addr (slot),
      .rd_data (flag_rdata)
   );

   assign ent_rd = rbq_pkg::entry_type'(ent_rdata);

   // operation sequencing and response build
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      pc_in        = pc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         rbq_pkg::ST_IDLE: begin
            if (req_fire) begin
               rsp_data_in = '0;
               case (req_data.mode)
                  rbq_pkg::MODE_ALLOC: begin
                     rsp_valid_in = 1'b1;
                     if (full) begin
                        rsp_data_in.status = rbq_pkg::STATUS_FULL;
                     end else begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  rbq_pkg::MODE_RETIRE: begin
                     if (empty) begin
                        rsp_data_in.status = rbq_pkg::STATUS_EMPTY;
                        rsp_valid_in       = 1'b1;
                     end else begin
                        head_in  = head_next;
                        count_in = count_ff - 1'b1;
                        state_in = rbq_pkg::ST_READ;
                     end
                  end
                  rbq_pkg::MODE_MARK: begin
                     rsp_valid_in = 1'b1;
                     if (!pos_ok) begin
                        rsp_data_in.status = rbq_pkg::STATUS_RANGE;
                     end
                  end
                  rbq_pkg::MODE_READ: begin
                     if (pos_ok) begin
                        state_in = rbq_pkg::ST_READ;
                     end else begin
                        rsp_data_in.status = rbq_pkg::STATUS_RANGE;
                        rsp_valid_in       = 1'b1;
                     end
                  end
                  rbq_pkg::MODE_FIND: begin
                     if (empty) begin
                        rsp_data_in.status = rbq_pkg::STATUS_NOPC;
                        rsp_valid_in       = 1'b1;
                     end else begin
                        idx_in   = '0;
                        pc_in    = req_data.instr_pc;
                        state_in = rbq_pkg::ST_SEARCH;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
               rsp_data_in.occupancy = rbq_pkg::OCC_W'(count_in);
            end
         end
         rbq_pkg::ST_READ: begin
            // entry read issued at the request edge is now on the memory output
            rsp_data_in.entry_tag        = ent_rd.tag;
            rsp_data_in.entry_old_tag    = ent_rd.old_tag;
            rsp_data_in.entry_pc         = ent_rd.pc;
            rsp_data_in.entry_dispatched = flag_rdata;
            rsp_valid_in                 = 1'b1;
            state_in                     = rbq_pkg::ST_IDLE;
         end
         rbq_pkg::ST_SEARCH: begin
            // compare the entry at idx, next read already issued
            if (ent_rd.pc == pc_ff) begin
               rsp_data_in.status         = rbq_pkg::STATUS_OK;
               rsp_data_in.found_position = rbq_pkg::POS_W'(idx_ff);
               rsp_valid_in               = 1'b1;
               state_in                   = rbq_pkg::ST_IDLE;
            end else if (idx_next == count_ff) begin
               rsp_data_in.status = rbq_pkg::STATUS_NOPC;
               rsp_valid_in       = 1'b1;
               state_in           = rbq_pkg::ST_IDLE;
            end else begin
               idx_in = idx_next;
            end
         end
         default: begin
            state_in = rbq_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rbq_pkg::ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pc_ff       <= pc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("occupancy above depth");

   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff != rbq_pkg::ST_IDLE) |-> !rsp_valid_ff)
      else $error("response pending while an operation is in flight");

   a_alloc_count: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_data.mode == rbq_pkg::MODE_ALLOC) && !full) |=>
      (count_ff == $past(count_ff) + 1'b1))
      else $error("allocate did not grow the queue");

   a_retire_read: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_data.mode == rbq_pkg::MODE_RETIRE) && !empty) |=>
      ((state_ff == rbq_pkg::ST_READ) && !rsp_valid_ff))
      else $error("retire did not wait for the entry read");

   a_search_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rbq_pkg::ST_SEARCH) |-> (idx_ff < count_ff))
      else $error("search offset beyond occupancy");
`endif

endmodule
`default_nettype wire

// ===== rtl/rbq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbq_ram
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module rbq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/rbq_addr.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbq_addr
// Maps an offset from the head to a memory slot, wrapping at the queue depth.
// ----------------------------------------------------------------------------
module rbq_addr #(
   parameter int DEPTH = rbq_pkg::DEPTH_DEF
) (
   input  wire logic [$clog2(DEPTH)-1:0]   head,
   input  wire logic [$clog2(DEPTH+1)-1:0] offset,
   output logic      [$clog2(DEPTH)-1:0]   slot
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int SUM_W = $clog2(2 * DEPTH);

   logic [SUM_W-1:0] sum;
   logic [SUM_W-1:0] wrapped;

   // head plus offset stays below twice the depth, one subtract wraps it
   always_comb begin
      sum = SUM_W'(head) + SUM_W'(offset);
      if (sum >= SUM_W'(DEPTH)) begin
         wrapped = sum - SUM_W'(DEPTH);
      end else begin
         wrapped = sum;
      end
   end

   assign slot = wrapped[IDX_W-1:0];

endmodule
`default_nettype wire
